// ===== hw/rtl/plca_pkg.sv =====
// ----------------------------------------------------------------------------
// plca_pkg
// Shared types and constants of the point light color accumulator.
// ----------------------------------------------------------------------------
package plca_pkg;

    localparam int CHAN_W   = 8;
    localparam int STR_W    = 9;
    localparam int POS_W    = 16;
    localparam int REACH_W  = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Magnitude of a position difference and its square.
    localparam int DIFF_W   = POS_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = SQ_W + 1;

    // Distance in Q.8, computed as the square root of a radicand of 2*ROOT_W bits.
    localparam int ROOT_W   = 26;
    localparam int FRAC_SH  = 16;

    // Scaled reach, scale product, channel product and quotient.
    localparam int DEN_W    = 24;
    localparam int MUL_W    = DEN_W + STR_W;
    localparam int NUM_W    = MUL_W + CHAN_W;
    localparam int REM_W    = NUM_W - 8;
    localparam int DV_W     = DEN_W + CHAN_W - 1;

    localparam logic [STR_W-1:0]  UNIT_STRENGTH = 9'd256;
    localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_RED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_GREEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_BLUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_STRENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_Y         = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQUARE,
        ST_ROOT,
        ST_TEST,
        ST_SCALE,
        ST_CHAN,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/plca_sermul.sv =====
// ----------------------------------------------------------------------------
// plca_sermul
// Unsigned shift-add multiplier that consumes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module plca_sermul #(
    parameter int A_W = 8,
    parameter int B_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;
    logic [P_W-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= {{B_W{1'b0}}, a};
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[P_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[B_W-1:1]};
        end
    end

    assign done    = busy_reg && (cnt_reg == LAST);
    assign product = acc_reg;

endmodule

// ===== hw/rtl/plca_isqrt.sv =====
// ----------------------------------------------------------------------------
// plca_isqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module plca_isqrt #(
    parameter int ROOT_W = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [ROOT_W+2:0] rem_shift;
    logic [ROOT_W+2:0] trial;
    logic              fits;

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (ROOT_W+1)'(rem_shift - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = busy_reg && (cnt_reg == LAST);
    assign root = root_reg;

endmodule

// ===== hw/rtl/plca_lane.sv =====
// ----------------------------------------------------------------------------
// plca_lane
// One color channel: serial product, serial quotient and saturating update of
// the running channel value.
// ----------------------------------------------------------------------------
module plca_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         load,
    input  logic [plca_pkg::CHAN_W-1:0]  color,
    input  logic [plca_pkg::MUL_W-1:0]   mul,
    input  logic [plca_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [plca_pkg::CHAN_W-1:0]  run
);

    logic                         mul_done;
    logic [plca_pkg::NUM_W-1:0]   product;

    logic                         load_reg;
    logic                         div_pend_reg;
    logic                         div_busy_reg;
    logic                         upd_reg;
    logic [2:0]                   div_cnt_reg;
    logic [plca_pkg::REM_W-1:0]   rem_reg;
    logic [plca_pkg::DV_W-1:0]    dv_reg;
    logic [plca_pkg::CHAN_W-1:0]  q_reg;
    logic [plca_pkg::CHAN_W-1:0]  run_reg;

    logic                         fits;
    logic [plca_pkg::CHAN_W:0]    sum;

    plca_sermul #(
        .A_W (plca_pkg::MUL_W),
        .B_W (plca_pkg::CHAN_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .a       (mul),
        .b       (color),
        .done    (mul_done),
        .product (product)
    );

    assign fits = (rem_reg >= {2'b00, dv_reg});
    assign sum  = {1'b0, (load_reg ? {plca_pkg::CHAN_W{1'b0}} : run_reg)} + {1'b0, q_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg     <= 1'b0;
            div_pend_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            upd_reg      <= 1'b0;
            div_cnt_reg  <= '0;
            run_reg      <= '0;
        end
        else
        begin
            if (start)
            begin
                load_reg <= load;
            end
            div_pend_reg <= mul_done;
            upd_reg      <= div_busy_reg && (div_cnt_reg == 3'd7);
            if (div_pend_reg)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                if (div_cnt_reg == 3'd7)
                begin
                    div_busy_reg <= 1'b0;
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (upd_reg)
            begin
                run_reg <= sum[plca_pkg::CHAN_W] ? plca_pkg::CHAN_MAX
                                                 : sum[plca_pkg::CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_pend_reg)
        begin
            rem_reg <= product[plca_pkg::NUM_W-1:8];
            dv_reg  <= {den, 7'b0};
            q_reg   <= '0;
        end
        else if (div_busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - {2'b00, dv_reg};
            end
            q_reg  <= {q_reg[plca_pkg::CHAN_W-2:0], fits};
            dv_reg <= {1'b0, dv_reg[plca_pkg::DV_W-1:1]};
        end
    end

    assign done = upd_reg;
    assign run  = run_reg;

endmodule

// ===== hw/rtl/point_light_color_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// point_light_color_accumulator_core
// Accumulates the lit color of a sprite over a pass of point lights.
// ----------------------------------------------------------------------------
// The block takes one word at a time and holds item_stall high while it works.
// A light that is not the first of its pass runs two bit-serial squares of
// the offsets, a bit-serial square root of the distance, the scale product,
// and the per-channel product and quotient, which run in three parallel
// lanes. A light out of reach or with zero reach ends after the square root.
// The first word of a pass first loads the ambient base through the same
// lanes. A finish word, after any base load, places the color in an output
// register, so the next pass may start while that result waits.
// ----------------------------------------------------------------------------
module point_light_color_accumulator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [plca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plca_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            func,
    input  logic signed [15:0]              light_x,
    input  logic signed [15:0]              light_y,
    input  logic [7:0]                      light_red,
    input  logic [7:0]                      light_green,
    input  logic [7:0]                      light_blue,
    input  logic [8:0]                      light_strength,
    input  logic [11:0]                     light_reach,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [7:0]                      lit_red,
    output logic [7:0]                      lit_green,
    output logic [7:0]                      lit_blue
);

    localparam int CW = plca_pkg::CHAN_W;

    plca_pkg::state_t state_reg;
    plca_pkg::state_t state_next;
    logic             go_reg;
    logic             go_next;

    logic [CW-1:0]                  amb_red_reg;
    logic [CW-1:0]                  amb_green_reg;
    logic [CW-1:0]                  amb_blue_reg;
    logic [plca_pkg::STR_W-1:0]     amb_str_reg;
    logic [plca_pkg::POS_W-1:0]     sprite_x_reg;
    logic [plca_pkg::POS_W-1:0]     sprite_y_reg;

    logic                           func_reg;
    logic [plca_pkg::POS_W-1:0]     lx_reg;
    logic [plca_pkg::POS_W-1:0]     ly_reg;
    logic [CW-1:0]                  lr_reg;
    logic [CW-1:0]                  lg_reg;
    logic [CW-1:0]                  lb_reg;
    logic [plca_pkg::STR_W-1:0]     ls_reg;
    logic [plca_pkg::REACH_W-1:0]   reach_reg;

    logic                           fresh_reg;
    logic                           out_valid_reg;
    logic [CW-1:0]                  lit_red_reg;
    logic [CW-1:0]                  lit_green_reg;
    logic [CW-1:0]                  lit_blue_reg;

    logic                           accept;
    logic                           emit;
    logic                           base_done;

    logic [plca_pkg::DIFF_W:0]      dx;
    logic [plca_pkg::DIFF_W:0]      dy;
    logic [plca_pkg::DIFF_W:0]      ndx;
    logic [plca_pkg::DIFF_W:0]      ndy;
    logic [plca_pkg::DIFF_W-1:0]    adx;
    logic [plca_pkg::DIFF_W-1:0]    ady;
    logic [plca_pkg::SQ_W-1:0]      sqx;
    logic [plca_pkg::SQ_W-1:0]      sqy;
    logic                           sqx_done;
    logic                           sqy_done;
    logic [2*plca_pkg::ROOT_W-1:0]  radicand;
    logic                           root_done;
    logic [plca_pkg::ROOT_W-1:0]    d8;

    logic [plca_pkg::STR_W-1:0]     amb_s;
    logic [plca_pkg::STR_W-1:0]     cap;
    logic [plca_pkg::STR_W-1:0]     lit_s;
    logic [plca_pkg::STR_W-1:0]     inten;
    logic [plca_pkg::DEN_W-1:0]     r8;
    logic [plca_pkg::DEN_W-1:0]     diff;
    logic                           no_light;
    logic                           scale_done;
    logic [plca_pkg::MUL_W-1:0]     scale;

    logic                           lane_start;
    logic                           lane_load;
    logic [plca_pkg::MUL_W-1:0]     lane_mul;
    logic [plca_pkg::DEN_W-1:0]     lane_den;
    logic [CW-1:0]                  col_red;
    logic [CW-1:0]                  col_green;
    logic [CW-1:0]                  col_blue;
    logic                           red_done;
    logic                           green_done;
    logic                           blue_done;
    logic                           lanes_done;
    logic [CW-1:0]                  run_red;
    logic [CW-1:0]                  run_green;
    logic [CW-1:0]                  run_blue;

    assign item_stall   = (state_reg != plca_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign emit         = (state_reg == plca_pkg::ST_EMIT)
                          && (!out_valid_reg || !result_stall);
    assign lanes_done   = red_done && green_done && blue_done;
    assign base_done    = (state_reg == plca_pkg::ST_BASE) && lanes_done;

    // Offsets from the light to twice the sprite position, as magnitudes.
    assign dx  = {lx_reg[15], lx_reg[15], lx_reg} - {sprite_x_reg[15], sprite_x_reg, 1'b0};
    assign dy  = {ly_reg[15], ly_reg[15], ly_reg} - {sprite_y_reg[15], sprite_y_reg, 1'b0};
    assign ndx = '0 - dx;
    assign ndy = '0 - dy;
    assign adx = dx[plca_pkg::DIFF_W] ? ndx[plca_pkg::DIFF_W-1:0] : dx[plca_pkg::DIFF_W-1:0];
    assign ady = dy[plca_pkg::DIFF_W] ? ndy[plca_pkg::DIFF_W-1:0] : dy[plca_pkg::DIFF_W-1:0];

    assign radicand = {1'b0, {1'b0, sqx} + {1'b0, sqy}, {plca_pkg::FRAC_SH{1'b0}}};

    assign amb_s = (amb_str_reg > plca_pkg::UNIT_STRENGTH) ? plca_pkg::UNIT_STRENGTH
                                                           : amb_str_reg;
    assign cap   = plca_pkg::UNIT_STRENGTH - amb_s;
    assign lit_s = (ls_reg > plca_pkg::UNIT_STRENGTH) ? plca_pkg::UNIT_STRENGTH : ls_reg;
    assign inten = (lit_s > cap) ? cap : lit_s;

    // Ten times the reach in Q.8 is reach * 2560 = reach * (2048 + 512).
    assign r8       = {1'b0, reach_reg, 11'b0} + {3'b000, reach_reg, 9'b0};
    assign no_light = (reach_reg == '0) || (d8 >= {2'b00, r8});
    assign diff     = r8 - d8[plca_pkg::DEN_W-1:0];

    assign lane_start = go_reg && ((state_reg == plca_pkg::ST_BASE)
                                   || (state_reg == plca_pkg::ST_CHAN));
    assign lane_load  = (state_reg == plca_pkg::ST_BASE);
    assign lane_mul   = lane_load ? {{(plca_pkg::MUL_W-plca_pkg::STR_W){1'b0}}, amb_s} : scale;
    assign lane_den   = lane_load ? plca_pkg::DEN_W'(1) : r8;
    assign col_red    = lane_load ? amb_red_reg : lr_reg;
    assign col_green  = lane_load ? amb_green_reg : lg_reg;
    assign col_blue   = lane_load ? amb_blue_reg : lb_reg;

    plca_sermul #(
        .A_W (plca_pkg::DIFF_W),
        .B_W (plca_pkg::DIFF_W)
    ) u_sqx (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg && (state_reg == plca_pkg::ST_SQUARE)),
        .a       (adx),
        .b       (adx),
        .done    (sqx_done),
        .product (sqx)
    );

    plca_sermul #(
        .A_W (plca_pkg::DIFF_W),
        .B_W (plca_pkg::DIFF_W)
    ) u_sqy (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg && (state_reg == plca_pkg::ST_SQUARE)),
        .a       (ady),
        .b       (ady),
        .done    (sqy_done),
        .product (sqy)
    );

    plca_isqrt #(
        .ROOT_W (plca_pkg::ROOT_W)
    ) u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg && (state_reg == plca_pkg::ST_ROOT)),
        .radicand (radicand),
        .done     (root_done),
        .root     (d8)
    );

    plca_sermul #(
        .A_W (plca_pkg::DEN_W),
        .B_W (plca_pkg::STR_W)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go_reg && (state_reg == plca_pkg::ST_SCALE)),
        .a       (diff),
        .b       (inten),
        .done    (scale_done),
        .product (scale)
    );

    plca_lane u_red (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .load  (lane_load),
        .color (col_red),
        .mul   (lane_mul),
        .den   (lane_den),
        .done  (red_done),
        .run   (run_red)
    );

    plca_lane u_green (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .load  (lane_load),
        .color (col_green),
        .mul   (lane_mul),
        .den   (lane_den),
        .done  (green_done),
        .run   (run_green)
    );

    plca_lane u_blue (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .load  (lane_load),
        .color (col_blue),
        .mul   (lane_mul),
        .den   (lane_den),
        .done  (blue_done),
        .run   (run_blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plca_pkg::ST_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        case (state_reg)
            plca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    go_next = 1'b1;
                    if (fresh_reg)
                    begin
                        state_next = plca_pkg::ST_BASE;
                    end
                    else if (func)
                    begin
                        state_next = plca_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = plca_pkg::ST_SQUARE;
                    end
                end
            end
            plca_pkg::ST_BASE:
            begin
                if (lanes_done)
                begin
                    go_next    = 1'b1;
                    state_next = func_reg ? plca_pkg::ST_EMIT : plca_pkg::ST_SQUARE;
                end
            end
            plca_pkg::ST_SQUARE:
            begin
                if (sqx_done && sqy_done)
                begin
                    go_next    = 1'b1;
                    state_next = plca_pkg::ST_ROOT;
                end
            end
            plca_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = plca_pkg::ST_TEST;
                end
            end
            plca_pkg::ST_TEST:
            begin
                if (no_light)
                begin
                    state_next = plca_pkg::ST_IDLE;
                end
                else
                begin
                    go_next    = 1'b1;
                    state_next = plca_pkg::ST_SCALE;
                end
            end
            plca_pkg::ST_SCALE:
            begin
                if (scale_done)
                begin
                    go_next    = 1'b1;
                    state_next = plca_pkg::ST_CHAN;
                end
            end
            plca_pkg::ST_CHAN:
            begin
                if (lanes_done)
                begin
                    state_next = plca_pkg::ST_IDLE;
                end
            end
            plca_pkg::ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = plca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_red_reg   <= '0;
            amb_green_reg <= '0;
            amb_blue_reg  <= '0;
            amb_str_reg   <= '0;
            sprite_x_reg  <= '0;
            sprite_y_reg  <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    plca_pkg::CFG_AMBIENT_RED:      amb_red_reg   <= cfg_data[7:0];
                    plca_pkg::CFG_AMBIENT_GREEN:    amb_green_reg <= cfg_data[7:0];
                    plca_pkg::CFG_AMBIENT_BLUE:     amb_blue_reg  <= cfg_data[7:0];
                    plca_pkg::CFG_AMBIENT_STRENGTH: amb_str_reg   <= cfg_data[8:0];
                    plca_pkg::CFG_SPRITE_X:         sprite_x_reg  <= cfg_data;
                    plca_pkg::CFG_SPRITE_Y:         sprite_y_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (base_done)
            begin
                fresh_reg <= 1'b0;
            end
            else if (emit)
            begin
                fresh_reg <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            lx_reg    <= light_x;
            ly_reg    <= light_y;
            lr_reg    <= light_red;
            lg_reg    <= light_green;
            lb_reg    <= light_blue;
            ls_reg    <= light_strength;
            reach_reg <= light_reach;
        end
        if (emit)
        begin
            lit_red_reg   <= run_red;
            lit_green_reg <= run_green;
            lit_blue_reg  <= run_blue;
        end
    end

    assign result_valid = out_valid_reg;
    assign lit_red      = lit_red_reg;
    assign lit_green    = lit_green_reg;
    assign lit_blue     = lit_blue_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives passes of point light words into the color accumulator and checks
// every emitted color against a cycle-free fixed point predictor, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic FUNC_ADD_LIGHT = 1'b0;
    localparam logic FUNC_FINISH    = 1'b1;
    localparam int   SETTLE_CYCLES  = 150;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   RANDOM_WORDS   = 830;

    typedef struct {
        logic               func;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [8:0]         strength;
        logic [11:0]        reach;
    } light_word_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lit_color_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_write;
    logic [plca_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [plca_pkg::CFG_W-1:0]       cfg_data;
    logic                             item_valid;
    logic                             item_stall;
    logic                             func;
    logic signed [15:0]               light_x;
    logic signed [15:0]               light_y;
    logic [7:0]                       light_red;
    logic [7:0]                       light_green;
    logic [7:0]                       light_blue;
    logic [8:0]                       light_strength;
    logic [11:0]                      light_reach;
    logic                             result_valid;
    logic                             result_stall;
    logic [7:0]                       lit_red;
    logic [7:0]                       lit_green;
    logic [7:0]                       lit_blue;

    // Predictor state: register copies and the running color of the pass.
    logic [7:0]             amb_red;
    logic [7:0]             amb_green;
    logic [7:0]             amb_blue;
    logic [8:0]             amb_strength;
    logic signed [15:0]     spr_x;
    logic signed [15:0]     spr_y;
    logic [7:0]             run_red;
    logic [7:0]             run_green;
    logic [7:0]             run_blue;
    logic                   pass_fresh;

    lit_color_t             expected_colors[$];
    int                     mismatches;
    int                     idle_cycles;
    int                     calm_words;
    int                     words_sent;

    point_light_color_accumulator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .light_x        (light_x),
        .light_y        (light_y),
        .light_red      (light_red),
        .light_green    (light_green),
        .light_blue     (light_blue),
        .light_strength (light_strength),
        .light_reach    (light_reach),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .lit_red        (lit_red),
        .lit_green      (lit_green),
        .lit_blue       (lit_blue)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned strength_clip(logic [8:0] s);
        return (s > plca_pkg::UNIT_STRENGTH) ? 256 : int'(s);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v)
            one = one >> 2;
        while (one != 0)
        begin
            if (v >= res + one)
            begin
                v = v - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] channel_sum(logic [7:0] run, logic [7:0] c,
                                               longint unsigned mul,
                                               longint unsigned den);
        longint unsigned sum;
        sum = longint'(run) + (longint'(c) * mul) / den;
        return (sum > 255) ? plca_pkg::CHAN_MAX : sum[7:0];
    endfunction

    function automatic void load_ambient_base();
        int unsigned s;
        s = strength_clip(amb_strength);
        run_red   = 8'((int'(amb_red) * s) >> 8);
        run_green = 8'((int'(amb_green) * s) >> 8);
        run_blue  = 8'((int'(amb_blue) * s) >> 8);
        pass_fresh = 1'b0;
    endfunction

    function automatic void predict_color(light_word_t w);
        longint signed   dx;
        longint signed   dy;
        longint unsigned d8;
        longint unsigned r8;
        longint unsigned mul;
        longint unsigned den;
        int unsigned     cap;
        int unsigned     inten;
        lit_color_t      color;
        if (pass_fresh)
            load_ambient_base();
        if (w.func == FUNC_FINISH)
        begin
            color.red   = run_red;
            color.green = run_green;
            color.blue  = run_blue;
            expected_colors = {expected_colors, color};
            pass_fresh = 1'b1;
            return;
        end
        dx = longint'(w.x) - 2 * longint'(spr_x);
        dy = longint'(w.y) - 2 * longint'(spr_y);
        d8 = root_floor(longint'(dx * dx + dy * dy) << 16);
        r8 = longint'(w.reach) * 2560;
        cap = 256 - strength_clip(amb_strength);
        inten = strength_clip(w.strength);
        if (inten > cap)
            inten = cap;
        if (w.reach == 0 || d8 >= r8)
            return;
        mul = longint'(inten) * (r8 - d8);
        den = 256 * r8;
        run_red   = channel_sum(run_red, w.red, mul, den);
        run_green = channel_sum(run_green, w.green, mul, den);
        run_blue  = channel_sum(run_blue, w.blue, mul, den);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] clip_pos(longint signed v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic light_word_t light_at(int x, int y, int r, int g, int b,
                                             int s, int reach);
        light_word_t w;
        w.func = FUNC_ADD_LIGHT;
        w.x = x[15:0];
        w.y = y[15:0];
        w.red = r[7:0];
        w.green = g[7:0];
        w.blue = b[7:0];
        w.strength = s[8:0];
        w.reach = reach[11:0];
        return w;
    endfunction

    function automatic light_word_t finish_word();
        light_word_t w;
        w = light_at($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        w.func = FUNC_FINISH;
        return w;
    endfunction

    function automatic light_word_t random_light();
        light_word_t w;
        int unsigned r;
        int          reach;
        int          lim;
        int          s;
        r = $urandom_range(0, 99);
        if (r < 10)
            return light_at($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        r = $urandom_range(0, 99);
        if (r < 5)
            reach = 0;
        else if (r < 70)
            reach = $urandom_range(1, 300);
        else if (r < 92)
            reach = $urandom_range(301, 4095);
        else
            reach = 4095;
        r = $urandom_range(0, 99);
        if (r < 80)
            s = $urandom_range(0, 256);
        else if (r < 90)
            s = $urandom_range(257, 511);
        else
            s = 256;
        lim = reach * 12;
        if (lim > 40000)
            lim = 40000;
        if (lim < 4)
            lim = 4;
        w = light_at(0, 0, $urandom, $urandom, $urandom, s, reach);
        w.x = clip_pos(2 * longint'(spr_x) + int'($urandom_range(0, 2 * lim)) - lim);
        w.y = clip_pos(2 * longint'(spr_y) + int'($urandom_range(0, 2 * lim)) - lim);
        return w;
    endfunction

    task automatic send_word(input light_word_t w);
        int unsigned gap;
        if (calm_words > 0)
        begin
            calm_words--;
            gap = 0;
        end
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid     <= 1'b1;
        func           <= w.func;
        light_x        <= w.x;
        light_y        <= w.y;
        light_red      <= w.red;
        light_green    <= w.green;
        light_blue     <= w.blue;
        light_strength <= w.strength;
        light_reach    <= w.reach;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_color(w);
        words_sent++;
    endtask

    task automatic release_item();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        release_item();
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [plca_pkg::CFG_IDX_W-1:0] idx, input int value);
        logic [plca_pkg::CFG_W-1:0] data;
        data = value[plca_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            plca_pkg::CFG_AMBIENT_RED:      amb_red = data[7:0];
            plca_pkg::CFG_AMBIENT_GREEN:    amb_green = data[7:0];
            plca_pkg::CFG_AMBIENT_BLUE:     amb_blue = data[7:0];
            plca_pkg::CFG_AMBIENT_STRENGTH: amb_strength = data[8:0];
            plca_pkg::CFG_SPRITE_X:         spr_x = data;
            plca_pkg::CFG_SPRITE_Y:         spr_y = data;
            default:                        ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_ambient(input int r, input int g, input int b, input int s);
        write_reg(plca_pkg::CFG_AMBIENT_RED, r);
        write_reg(plca_pkg::CFG_AMBIENT_GREEN, g);
        write_reg(plca_pkg::CFG_AMBIENT_BLUE, b);
        write_reg(plca_pkg::CFG_AMBIENT_STRENGTH, s);
    endtask

    task automatic write_sprite(input int x, input int y);
        write_reg(plca_pkg::CFG_SPRITE_X, x);
        write_reg(plca_pkg::CFG_SPRITE_Y, y);
    endtask

    task automatic shuffle_setup();
        int unsigned r;
        wait_quiet();
        if ($urandom_range(0, 1))
            write_reg(plca_pkg::CFG_AMBIENT_RED, $urandom_range(0, 255));
        if ($urandom_range(0, 1))
            write_reg(plca_pkg::CFG_AMBIENT_GREEN, $urandom_range(0, 255));
        if ($urandom_range(0, 1))
            write_reg(plca_pkg::CFG_AMBIENT_BLUE, $urandom_range(0, 255));
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                write_reg(plca_pkg::CFG_AMBIENT_STRENGTH, $urandom_range(0, 160));
            else if (r < 90)
                write_reg(plca_pkg::CFG_AMBIENT_STRENGTH, $urandom_range(161, 256));
            else
                write_reg(plca_pkg::CFG_AMBIENT_STRENGTH, $urandom_range(257, 511));
        end
        if ($urandom_range(0, 1))
        begin
            if ($urandom_range(0, 5) == 0)
                write_sprite($urandom, $urandom);
            else
                write_sprite(int'($urandom_range(0, 32000)) - 16000,
                             int'($urandom_range(0, 32000)) - 16000);
        end
    endtask

    task automatic test_empty_pass();
        send_word(finish_word());
    endtask

    task automatic test_ambient_base();
        wait_quiet();
        write_ambient(255, 128, 1, 256);
        send_word(finish_word());
        wait_quiet();
        write_reg(plca_pkg::CFG_AMBIENT_STRENGTH, 511);
        send_word(finish_word());
        wait_quiet();
        write_reg(plca_pkg::CFG_AMBIENT_STRENGTH, 100);
        send_word(finish_word());
    endtask

    task automatic test_light_falloff();
        wait_quiet();
        write_ambient(0, 0, 0, 0);
        write_sprite(0, 0);
        send_word(light_at(0, 0, 255, 255, 255, 256, 4095));
        send_word(finish_word());
        send_word(light_at(0, 0, 255, 128, 7, 511, 4095));
        send_word(light_at(0, 0, 200, 200, 200, 256, 0));
        send_word(light_at(10, 0, 200, 200, 200, 256, 1));
        send_word(light_at(9, 0, 100, 100, 100, 256, 1));
        send_word(finish_word());
        wait_quiet();
        write_sprite(32767, -32768);
        send_word(light_at(-32768, 32767, 255, 255, 255, 256, 4095));
        wait_quiet();
        write_sprite(-32768, 0);
        send_word(light_at(-32768, 0, 90, 60, 30, 128, 4095));
        send_word(finish_word());
    endtask

    task automatic test_base_timing();
        wait_quiet();
        write_ambient(40, 80, 120, 128);
        write_sprite(0, 0);
        send_word(light_at(0, 0, 100, 100, 100, 256, 4095));
        wait_quiet();
        write_ambient(200, 200, 200, 64);
        send_word(light_at(0, 0, 100, 100, 100, 256, 4095));
        send_word(finish_word());
        send_word(finish_word());
    endtask

    task automatic test_random_passes();
        int unsigned r;
        int          lights;
        int          target;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                shuffle_setup();
            if ($urandom_range(0, 9) == 0)
                calm_words = $urandom_range(10, 40);
            r = $urandom_range(0, 99);
            if (r < 8)
                lights = 0;
            else if (r < 85)
                lights = $urandom_range(1, 4);
            else if (r < 97)
                lights = $urandom_range(5, 8);
            else
                lights = $urandom_range(9, 15);
            repeat (lights)
            begin
                send_word(random_light());
                if ($urandom_range(0, 32) == 0)
                    shuffle_setup();
            end
            send_word(finish_word());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = plca_pkg::CFG_AMBIENT_RED;
        cfg_data       = '0;
        item_valid     = 1'b0;
        func           = FUNC_ADD_LIGHT;
        light_x        = '0;
        light_y        = '0;
        light_red      = '0;
        light_green    = '0;
        light_blue     = '0;
        light_strength = '0;
        light_reach    = '0;
        amb_red        = '0;
        amb_green      = '0;
        amb_blue       = '0;
        amb_strength   = '0;
        spr_x          = '0;
        spr_y          = '0;
        run_red        = '0;
        run_green      = '0;
        run_blue       = '0;
        pass_fresh     = 1'b1;
        mismatches     = 0;
        calm_words     = 0;
        words_sent     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pass();
        test_ambient_base();
        test_light_falloff();
        test_base_timing();
        test_random_passes();

        wait_quiet();
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("point_light_color_accumulator_core: match");
        else
            $display("point_light_color_accumulator_core: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned busy;
        int unsigned free;
        result_stall = 1'b0;
        forever
        begin
            busy = pick_gap();
            free = $urandom_range(0, 30);
            if (busy > 0)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (busy - 1) @(negedge clk);
            end
            @(negedge clk);
            result_stall <= 1'b0;
            repeat (free) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        lit_color_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("color error: unexpected word %0d %0d %0d",
                             lit_red, lit_green, lit_blue);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (lit_red !== want.red || lit_green !== want.green ||
                    lit_blue !== want.blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color error: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.red, want.green, want.blue,
                                 lit_red, lit_green, lit_blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("point_light_color_accumulator_core: mismatch");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
